[rtl/core/gpm_pkg.sv]
package gpm_pkg;

  localparam logic [1:0] ModeAmbi  = 2'd0;
  localparam logic [1:0] ModeLeft  = 2'd1;
  localparam logic [1:0] ModeRight = 2'd2;

  localparam logic [7:0] AxisCentre  = 8'd128;
  localparam logic [7:0] AxisLow     = 8'd1;
  localparam logic [7:0] AxisHigh    = 8'd254;
  localparam logic [7:0] DeflectLim  = 8'd64;
  localparam logic [7:0] XBias       = 8'd2;

  // Reciprocal of ten in 14 fractional bits; exact for products up to 1152.
  localparam int unsigned RecipTen   = 1639;
  localparam int unsigned RecipShift = 14;

  typedef struct packed {
    logic [7:0] right_x;
    logic [7:0] right_y;
    logic [7:0] left_x;
    logic [7:0] left_y;
    logic [7:0] button_byte_a;
    logic [7:0] button_byte_b;
    logic       joy_north;
    logic       joy_south;
    logic       joy_west;
    logic       joy_east;
    logic       fire_a_in;
    logic       fire_b_in;
  } item_in_t;

  typedef struct packed {
    logic [7:0] pot0_horiz;
    logic [7:0] pot0_vert;
    logic [7:0] pot1_horiz;
    logic [7:0] pot1_vert;
    logic       pot1_update;
    logic       trigger_a_level;
    logic       trigger_b_level;
    logic [2:0] keypad_rows;
  } item_out_t;

  function automatic logic [7:0] axis_dist(input logic [7:0] v);
    axis_dist = v[7] ? (v - AxisCentre) : (AxisCentre - v);
  endfunction

  function automatic logic [7:0] axis_map(input logic [7:0] v, input logic is_x);
    logic [7:0]  mag;
    logic [10:0] mag9;
    logic [21:0] prod;
    logic [7:0]  q;
    logic [7:0]  d;
    mag  = axis_dist(v);
    mag9 = {3'b000, mag} * 11'd9;
    prod = {11'd0, mag9} * 22'(RecipTen);
    q    = prod[RecipShift +: 8];
    d    = v[7] ? q : (8'd0 - q);
    axis_map = d + AxisCentre + (is_x ? XBias : 8'd0);
  endfunction

endpackage

[rtl/core/gpm_in_stage.sv]
module gpm_in_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  gpm_pkg::item_in_t   in_item_i,
  output logic                stage_valid_o,
  input  logic                stage_adv_i,
  output gpm_pkg::item_in_t   stage_item_o
);

  logic              valid_q, valid_d;
  gpm_pkg::item_in_t item_q;

  assign in_ready_o = !valid_q || stage_adv_i;
  assign valid_d    = (in_valid_i && in_ready_o) || (valid_q && !stage_adv_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_item_i;
    end
  end

  assign stage_valid_o = valid_q;
  assign stage_item_o  = item_q;

endmodule

[rtl/core/gpm_mapper.sv]
module gpm_mapper (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  gpm_pkg::item_in_t  item_i,
  output gpm_pkg::item_out_t res_o
);

  logic [1:0] mode_q, mode_d;
  logic       choice_q, choice_d;
  logic       sel, override, ambi, rdev, ldev, choice_now;
  logic [7:0] hd, vd, sx, sy;
  logic       ta, tb;

  always_comb begin
    sel      = !item_i.button_byte_a[0];
    hd       = gpm_pkg::AxisCentre;
    vd       = gpm_pkg::AxisCentre;
    if (item_i.joy_north) begin
      vd = gpm_pkg::AxisLow;
    end else if (item_i.joy_south) begin
      vd = gpm_pkg::AxisHigh;
    end
    if (item_i.joy_west) begin
      hd = gpm_pkg::AxisLow;
    end else if (item_i.joy_east) begin
      hd = gpm_pkg::AxisHigh;
    end
    override = item_i.joy_north || item_i.joy_south || item_i.joy_west || item_i.joy_east;

    rdev = (gpm_pkg::axis_dist(item_i.right_x) > gpm_pkg::DeflectLim) ||
           (gpm_pkg::axis_dist(item_i.right_y) > gpm_pkg::DeflectLim);
    ldev = (gpm_pkg::axis_dist(item_i.left_x) > gpm_pkg::DeflectLim) ||
           (gpm_pkg::axis_dist(item_i.left_y) > gpm_pkg::DeflectLim);
    if (rdev) begin
      choice_now = 1'b0;
    end else if (ldev) begin
      choice_now = 1'b1;
    end else begin
      choice_now = choice_q;
    end

    ambi = 1'b0;
    res_o = '0;
    sx = choice_now ? item_i.left_x : item_i.right_x;
    sy = choice_now ? item_i.left_y : item_i.right_y;
    if (override) begin
      res_o.pot0_horiz = hd;
      res_o.pot0_vert  = vd;
    end else begin
      res_o.pot1_update = 1'b1;
      case (mode_q)
        gpm_pkg::ModeLeft: begin
          res_o.pot0_horiz = gpm_pkg::axis_map(item_i.left_x, 1'b1);
          res_o.pot0_vert  = gpm_pkg::axis_map(item_i.left_y, 1'b0);
          res_o.pot1_horiz = gpm_pkg::axis_map(item_i.right_x, 1'b1);
          res_o.pot1_vert  = gpm_pkg::axis_map(item_i.right_y, 1'b0);
        end
        gpm_pkg::ModeRight: begin
          res_o.pot0_horiz = gpm_pkg::axis_map(item_i.right_x, 1'b1);
          res_o.pot0_vert  = gpm_pkg::axis_map(item_i.right_y, 1'b0);
          res_o.pot1_horiz = gpm_pkg::axis_map(item_i.left_x, 1'b1);
          res_o.pot1_vert  = gpm_pkg::axis_map(item_i.left_y, 1'b0);
        end
        default: begin
          ambi = 1'b1;
          res_o.pot0_horiz = gpm_pkg::axis_map(sx, 1'b1);
          res_o.pot0_vert  = gpm_pkg::axis_map(sy, 1'b0);
          res_o.pot1_horiz = res_o.pot0_horiz;
          res_o.pot1_vert  = res_o.pot0_vert;
        end
      endcase
    end

    mode_d = mode_q;
    if (sel) begin
      if (!item_i.button_byte_b[4]) begin
        mode_d = gpm_pkg::ModeAmbi;
      end else if (!item_i.button_byte_b[7]) begin
        mode_d = gpm_pkg::ModeLeft;
      end else if (!item_i.button_byte_b[5]) begin
        mode_d = gpm_pkg::ModeRight;
      end
      res_o.keypad_rows[2] = !item_i.button_byte_a[3];
      res_o.keypad_rows[1] = !item_i.button_byte_b[6];
    end else begin
      res_o.keypad_rows[0] = !item_i.button_byte_a[3];
    end
    choice_d = ambi ? choice_now : choice_q;

    ta = (!sel && (item_i.button_byte_b[4:2] != 3'b111)) || item_i.fire_a_in;
    tb = (!sel && ({item_i.button_byte_b[6], item_i.button_byte_b[1:0]} != 3'b111)) ||
         item_i.fire_b_in;
    res_o.trigger_a_level = !ta;
    res_o.trigger_b_level = !tb;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= gpm_pkg::ModeAmbi;
      choice_q <= 1'b0;
    end else if (adv_i) begin
      mode_q   <= mode_d;
      choice_q <= choice_d;
    end
  end

endmodule

[rtl/core/gamepad_to_pot_mapper.sv]
// Channel | Direction | Handshake                 | Payload
// input   | in        | in_valid_i / in_ready_o   | in_item_i  (gpm_pkg::item_in_t)
// output  | out       | out_valid_o / out_ready_i | out_item_o (gpm_pkg::item_out_t)
//
// Each item passes an input register and a result register: the mapping between them is
// combinational, and its result is valid once the item has moved into the result register.
// One item per cycle is sustained while the output is not stalled, set by the single mapping stage.
// The mode and stick choice update as an item moves into the result register.
// Reset clears both valid flags, the mode (ambidextrous) and the stick choice (right).
// A stalled output holds its result while the input register, if empty, still takes one more item.
module gamepad_to_pot_mapper (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  gpm_pkg::item_in_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output gpm_pkg::item_out_t out_item_o
);

  logic               stage_valid, stage_adv;
  gpm_pkg::item_in_t  stage_item;
  gpm_pkg::item_out_t res;
  logic               out_valid_q, out_valid_d;
  gpm_pkg::item_out_t out_item_q;

  gpm_in_stage u_in_stage (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_item_i     (in_item_i),
    .stage_valid_o (stage_valid),
    .stage_adv_i   (stage_adv),
    .stage_item_o  (stage_item)
  );

  gpm_mapper u_mapper (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (stage_adv),
    .item_i (stage_item),
    .res_o  (res)
  );

  assign stage_adv   = stage_valid && (!out_valid_q || out_ready_i);
  assign out_valid_d = stage_adv || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_adv) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

[rtl/core/gpm_checker.sv]
module gpm_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input gpm_pkg::item_out_t out_item_o
);

  // A result that waits is neither dropped nor altered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("Stalled result item changed or vanished.");

  // Without a pot pair 1 write, pot pair 1 reads as zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.pot1_update |->
      out_item_o.pot1_horiz == 8'd0 && out_item_o.pot1_vert == 8'd0)
    else $error("Pot pair 1 not cleared on a joystick override.");

  // An override gives raw positions and never a centred pair.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.pot1_update |->
      (out_item_o.pot0_horiz == 8'd1 || out_item_o.pot0_horiz == 8'd128 ||
       out_item_o.pot0_horiz == 8'd254) &&
      (out_item_o.pot0_vert == 8'd1 || out_item_o.pot0_vert == 8'd128 ||
       out_item_o.pot0_vert == 8'd254) &&
      !(out_item_o.pot0_horiz == 8'd128 && out_item_o.pot0_vert == 8'd128))
    else $error("Override result outside the raw positions.");

  // The start row belongs to the unselected case, pause and reset to the selected one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.keypad_rows[0] |->
      !out_item_o.keypad_rows[1] && !out_item_o.keypad_rows[2])
    else $error("Start row pulled together with pause or reset row.");

endmodule

bind gamepad_to_pot_mapper gpm_checker u_gpm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);
